/* src/dtsm_pkg.sv */
package dtsm_pkg;

    // Default configuration of the synthesizer
    localparam int DEF_PHASE_WIDTH     = 32;
    localparam int DEF_TABLE_ADDR_BITS = 10;
    localparam int QUEUE_DEPTH         = 4;

    // Field widths
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int STEP_WIDTH      = 32;
    localparam int GAIN_WIDTH      = 15;
    localparam int SINE_WIDTH      = 15;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int PROD_WIDTH      = 31;
    localparam int SUM_WIDTH       = 32;
    localparam int S_TDATA_WIDTH   = 8;
    localparam int M_TDATA_WIDTH   = 16;
    localparam int FRAC_SHIFT      = 15;

    // Register reset values
    localparam logic [STEP_WIDTH-1:0] STEP_A_RESET = 32'd42852281;
    localparam logic [GAIN_WIDTH-1:0] GAIN_A_RESET = 15'd13107;
    localparam logic [STEP_WIDTH-1:0] STEP_B_RESET = 32'd292174645;
    localparam logic [GAIN_WIDTH-1:0] GAIN_B_RESET = 15'd4915;

    // Saturation limits and truncation bias
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [SUM_WIDTH-1:0]    TRUNC_BIAS = 32'd32767;

    // Register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TONE_A_STEP = 2'd0,
        REG_TONE_A_GAIN = 2'd1,
        REG_TONE_B_STEP = 2'd2,
        REG_TONE_B_GAIN = 2'd3
    } cfg_reg_e;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Sine table generation constants (evaluated at elaboration)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] ROUND_HALF  = 64'd536870912;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

    // Q2.30 sine by a nine-term Taylor series
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // Quarter-wave table entry k in unsigned Q0.15, rounded and capped
    function automatic logic [SINE_WIDTH-1:0] sine_entry(input int unsigned k,
                                                        input int unsigned addr_bits);
        logic [63:0] x;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
        v = (sine_q30(x) * FULL_SCALE + ROUND_HALF) >> 30;
        if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return v[SINE_WIDTH-1:0];
    endfunction

endpackage

/* src/dtsm_queue.sv */
module dtsm_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       head_data,
    output dtsm_pkg::q_status_t    status
);
    import dtsm_pkg::*;

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

    logic [WIDTH-1:0]     mem_reg [DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

/* src/dtsm_front.sv */
module dtsm_front #(
    parameter int PHASE_WIDTH     = dtsm_pkg::DEF_PHASE_WIDTH,
    parameter int TABLE_ADDR_BITS = dtsm_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              restart,
    input  logic [PHASE_WIDTH-1:0]            step_a,
    input  logic [PHASE_WIDTH-1:0]            step_b,
    input  dtsm_pkg::q_status_t               q_status,
    output logic                              push,
    output logic [2*(TABLE_ADDR_BITS+2)-1:0]  push_data
);
    import dtsm_pkg::*;

    localparam int AW = TABLE_ADDR_BITS + 2;

    logic [PHASE_WIDTH-1:0] phase_a_reg, phase_a_next;
    logic [PHASE_WIDTH-1:0] phase_b_reg, phase_b_next;
    logic [PHASE_WIDTH-1:0] cur_a, cur_b;

    // Take an item whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // Phases used by this sample; restart zeroes them first
    assign cur_a = restart ? '0 : phase_a_reg;
    assign cur_b = restart ? '0 : phase_b_reg;

    assign phase_a_next = cur_a + step_a;
    assign phase_b_next = cur_b + step_b;

    // Only the quadrant and table index go on to the back end
    assign push_data = {cur_b[PHASE_WIDTH-1 -: AW], cur_a[PHASE_WIDTH-1 -: AW]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_a_reg <= '0;
            phase_b_reg <= '0;
        end else if (push) begin
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
        end
    end

endmodule

/* src/dtsm_sine_rom.sv */
module dtsm_sine_rom #(
    parameter int TABLE_ADDR_BITS = dtsm_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [TABLE_ADDR_BITS+1:0]             addr,
    output logic signed [dtsm_pkg::SAMPLE_WIDTH-1:0] sine
);
    import dtsm_pkg::*;

    localparam int Q = 1 << TABLE_ADDR_BITS;

    logic [SINE_WIDTH-1:0] sine_tbl [0:Q];

    // Fill the quarter-wave table from constant entries
    for (genvar gi = 0; gi <= Q; gi++) begin : g_tbl
        localparam logic [SINE_WIDTH-1:0] ENTRY = sine_entry(gi, TABLE_ADDR_BITS);
        assign sine_tbl[gi] = ENTRY;
    end

    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] k;
    logic [TABLE_ADDR_BITS:0]   idx;
    logic [SINE_WIDTH-1:0]      val_reg;
    logic                       neg_reg;

    // Mirror the index in odd quadrants
    assign quad = addr[TABLE_ADDR_BITS+1 -: 2];
    assign k    = addr[TABLE_ADDR_BITS-1:0];
    assign idx  = quad[0] ? ((TABLE_ADDR_BITS+1)'(Q) - {1'b0, k}) : {1'b0, k};

    // Registered table read
    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= sine_tbl[idx];
            neg_reg <= quad[1];
        end
    end

    // Apply the sign after the registered read
    assign sine = neg_reg ? -$signed({1'b0, val_reg}) : $signed({1'b0, val_reg});

endmodule

/* src/dtsm_back.sv */
module dtsm_back #(
    parameter int TABLE_ADDR_BITS = dtsm_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dtsm_pkg::q_status_t                   q_status,
    input  logic [2*(TABLE_ADDR_BITS+2)-1:0]      head_data,
    output logic                                  pop,
    input  logic [dtsm_pkg::GAIN_WIDTH-1:0]       gain_a,
    input  logic [dtsm_pkg::GAIN_WIDTH-1:0]       gain_b,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dtsm_pkg::SAMPLE_WIDTH-1:0]     sample,
    output logic                                  clipped
);
    import dtsm_pkg::*;

    localparam int AW = TABLE_ADDR_BITS + 2;

    logic                           en;
    logic                           v1_reg, v2_reg, v3_reg;
    logic signed [SAMPLE_WIDTH-1:0] sine_a, sine_b;
    logic signed [31:0]             mul_a, mul_b;
    logic signed [PROD_WIDTH-1:0]   prod_a_reg, prod_b_reg;
    logic signed [SUM_WIDTH-1:0]    sum;
    logic signed [SUM_WIDTH-1:0]    biased;
    logic signed [SAMPLE_WIDTH:0]   trunc;
    logic [SAMPLE_WIDTH-1:0]        sample_reg, sample_next;
    logic                           clip_reg, clip_next;

    // Move the whole pipe unless the output is held
    assign en  = !v3_reg || m_tready;
    assign pop = en && !q_status.empty;

    // Stage 1: table lookups
    dtsm_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_a (
        .aclk (aclk),
        .en   (en),
        .addr (head_data[AW-1:0]),
        .sine (sine_a)
    );

    dtsm_sine_rom #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_rom_b (
        .aclk (aclk),
        .en   (en),
        .addr (head_data[2*AW-1:AW]),
        .sine (sine_b)
    );

    // Stage 2: scale by gains
    assign mul_a = 32'(sine_a) * 32'($signed({1'b0, gain_a}));
    assign mul_b = 32'(sine_b) * 32'($signed({1'b0, gain_b}));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_a_reg <= mul_a[PROD_WIDTH-1:0];
            prod_b_reg <= mul_b[PROD_WIDTH-1:0];
        end
    end

    // Stage 3: mix, truncate toward zero, saturate
    always_comb begin
        sum    = SUM_WIDTH'(prod_a_reg) + SUM_WIDTH'(prod_b_reg);
        biased = sum + (sum[SUM_WIDTH-1] ? $signed(TRUNC_BIAS) : '0);
        trunc  = biased[SUM_WIDTH-1:FRAC_SHIFT];
        clip_next = trunc[SAMPLE_WIDTH] ^ trunc[SAMPLE_WIDTH-1];
        if (clip_next) begin
            sample_next = trunc[SAMPLE_WIDTH] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            sample_next = trunc[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign sample   = sample_reg;
    assign clipped  = clip_reg;

endmodule

/* src/dual_tone_sine_mixer.sv */
// Dual-tone sine mixer: two phase accumulators, quarter-wave sine lookup, gain and sum.
// A result passes through the queue, table read, multiply and mix/saturate registers,
// and stays in them longer while the output is held.
// Throughput: one sample per cycle while the output is not held; a four-entry queue keeps
// input transfers going while the output is stalled, until it fills.
// Reset (aresetn low, synchronous): phases zero, registers to defaults, queue and pipe empty.
module dual_tone_sine_mixer #(
    parameter int PHASE_WIDTH     = dtsm_pkg::DEF_PHASE_WIDTH,
    parameter int TABLE_ADDR_BITS = dtsm_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [dtsm_pkg::S_TDATA_WIDTH-1:0]     s_tdata,   // [0] restart
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [dtsm_pkg::M_TDATA_WIDTH-1:0]     m_tdata,   // [15:0] sample
    output logic [0:0]                             m_tuser,   // [0] clipped
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dtsm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [dtsm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import dtsm_pkg::*;

    localparam int AW = TABLE_ADDR_BITS + 2;

    logic [PHASE_WIDTH-1:0] step_a_reg, step_b_reg;
    logic [GAIN_WIDTH-1:0]  gain_a_reg, gain_b_reg;
    logic                   cfg_write;

    q_status_t              q_status;
    logic                   push, pop;
    logic [2*AW-1:0]        push_data, head_data;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                   clipped;

    // Register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_a_reg <= PHASE_WIDTH'(STEP_A_RESET);
            gain_a_reg <= GAIN_A_RESET;
            step_b_reg <= PHASE_WIDTH'(STEP_B_RESET);
            gain_b_reg <= GAIN_B_RESET;
        end else if (cfg_write) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_TONE_A_STEP: step_a_reg <= PHASE_WIDTH'(cfg_data);
                REG_TONE_A_GAIN: gain_a_reg <= cfg_data[GAIN_WIDTH-1:0];
                REG_TONE_B_STEP: step_b_reg <= PHASE_WIDTH'(cfg_data);
                REG_TONE_B_GAIN: gain_b_reg <= cfg_data[GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    dtsm_front #(
        .PHASE_WIDTH     (PHASE_WIDTH),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .restart   (s_tdata[0]),
        .step_a    (step_a_reg),
        .step_b    (step_b_reg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    dtsm_queue #(
        .WIDTH (2*AW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    dtsm_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_data (head_data),
        .pop       (pop),
        .gain_a    (gain_a_reg),
        .gain_b    (gain_b_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sample    (sample),
        .clipped   (clipped)
    );

    assign m_tdata    = sample;
    assign m_tuser[0] = clipped;

    // Never pop an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // Queue cannot be full and empty at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // A clip flag only comes with a rail value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == SAMPLE_MAX || m_tdata == SAMPLE_MIN))
        else $error("clip flag without saturated sample");

endmodule

/* verif/dual_tone_sine_mixer_tb.sv */
`timescale 1ns / 1ps

module dual_tone_sine_mixer_tb;
    import dtsm_pkg::*;

    localparam int          QTR            = 1 << DEF_TABLE_ADDR_BITS;
    localparam int          LATENCY        = 3;
    localparam int          TIMEOUT_CYCLES = 400000;
    localparam int          MAX_PRINTS     = 40;
    localparam longint unsigned HALF_PI    = 64'd1686629713;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           clipped;
    } tone_sample_t;

    // Clock, reset and DUT ports
    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [S_TDATA_WIDTH-1:0]    s_tdata   = '0;   // [0] restart
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [M_TDATA_WIDTH-1:0]    m_tdata;          // [15:0] sample
    logic [0:0]                  m_tuser;          // [0] clipped
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    cfg_reg_e                    cfg_index = REG_TONE_A_STEP;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data  = '0;

    // Predictor state: phases and tone settings
    logic [STEP_WIDTH-1:0]       ph_a     = '0;
    logic [STEP_WIDTH-1:0]       ph_b     = '0;
    logic [STEP_WIDTH-1:0]       step_a   = STEP_A_RESET;
    logic [STEP_WIDTH-1:0]       step_b   = STEP_B_RESET;
    logic [GAIN_WIDTH-1:0]       gain_a   = GAIN_A_RESET;
    logic [GAIN_WIDTH-1:0]       gain_b   = GAIN_B_RESET;
    int                          sine_rom [0:QTR];

    // Stimulus and scoreboard storage
    bit                          restart_pending [$];
    tone_sample_t                expected_samples [$];
    int                          mismatches    = 0;
    int                          send_idle_pct = 29;
    int                          recv_idle_pct = 62;
    logic                        hold_input    = 1'b0;
    int                          cycle_count   = 0;
    logic                        bus_free;
    bit                          next_restart;

    dual_tone_sine_mixer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    // Q2.30 sine from the truncated Taylor series
    function automatic longint unsigned taylor_sine(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned div;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
            div  = 64'(2 * n * (2 * n + 1));
            term = ((term * x2) >> 30) / div;
            if (n % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    function automatic void build_sine_rom();
        longint unsigned x;
        longint unsigned v;
        for (int k = 0; k <= QTR; k++) begin
            x = (HALF_PI * longint'(k)) / QTR;
            v = (taylor_sine(x) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            sine_rom[k] = int'(v);
        end
    endfunction

    // Quadrant from the top two bits, mirrored index in odd quadrants
    function automatic int quarter_lookup(logic [STEP_WIDTH-1:0] ph);
        logic [1:0]                     quad;
        logic [DEF_TABLE_ADDR_BITS-1:0] k;
        int                             v;
        quad = ph[STEP_WIDTH-1 -: 2];
        k    = ph[STEP_WIDTH-3 -: DEF_TABLE_ADDR_BITS];
        v    = quad[0] ? sine_rom[QTR - int'(k)] : sine_rom[k];
        return quad[1] ? -v : v;
    endfunction

    // Form one mixed sample, then advance both phases
    function automatic void predict_sample(bit restart);
        longint       mix;
        longint       trunc;
        longint       ga;
        longint       gb;
        tone_sample_t e;
        if (restart) begin
            ph_a = '0;
            ph_b = '0;
        end
        ga    = longint'(gain_a);
        gb    = longint'(gain_b);
        mix   = longint'(quarter_lookup(ph_a)) * ga + longint'(quarter_lookup(ph_b)) * gb;
        trunc = mix / 32768;
        e.clipped = 1'b0;
        if (trunc > 32767) begin
            trunc     = 32767;
            e.clipped = 1'b1;
        end else if (trunc < -32768) begin
            trunc     = -32768;
            e.clipped = 1'b1;
        end
        e.sample = trunc[SAMPLE_WIDTH-1:0];
        expected_samples.push_back(e);
        ph_a = ph_a + step_a;
        ph_b = ph_b + step_b;
    endfunction

    // Input driver: hold the item until its transfer, then load the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            bus_free = !s_tvalid || s_tready;
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata[0]);
            end
            if (bus_free) begin
                if (!hold_input && restart_pending.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_restart = restart_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_WIDTH'(next_restart);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor: compare each transfer with the oldest expected sample
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                flag_mismatch("sample with none expected", $signed(m_tdata), 0);
            end else begin
                if (m_tdata !== expected_samples[0].sample) begin
                    flag_mismatch("sample", $signed(m_tdata),
                                  expected_samples[0].sample);
                end
                if (m_tuser[0] !== expected_samples[0].clipped) begin
                    flag_mismatch("clipped", m_tuser[0], expected_samples[0].clipped);
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TONE_A_STEP: step_a = value;
            REG_TONE_A_GAIN: gain_a = value[GAIN_WIDTH-1:0];
            REG_TONE_B_STEP: step_b = value;
            REG_TONE_B_GAIN: gain_b = value[GAIN_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Wait until every item is sent and every sample is back
    task automatic drain();
        while (restart_pending.size() != 0 || s_tvalid || expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic load_tones(logic [31:0] a_step, logic [31:0] a_gain,
                              logic [31:0] b_step, logic [31:0] b_gain);
        drain();
        write_reg(REG_TONE_A_STEP, a_step);
        write_reg(REG_TONE_A_GAIN, a_gain);
        write_reg(REG_TONE_B_STEP, b_step);
        write_reg(REG_TONE_B_GAIN, b_gain);
    endtask

    function automatic logic [31:0] pick_step();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h0000_0000;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom_range(0, 32'h00FF_FFFF);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Upper data bits stay random so the gain field masking is exercised
    function automatic logic [31:0] pick_gain(bit loud);
        logic [31:0] v;
        v = $urandom();
        if (loud) begin
            v[14:0] = 15'($urandom_range(24000, 32767));
        end else begin
            case ($urandom_range(0, 5))
                0: v[14:0] = 15'h0000;
                1: v[14:0] = 15'h7FFF;
                default: ;
            endcase
        end
        return v;
    endfunction

    task automatic queue_restarts(int count, int restart_pct);
        for (int i = 0; i < count; i++) begin
            restart_pending.push_back($urandom_range(0, 99) < restart_pct);
        end
    endtask

    initial begin
        build_sine_rom();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset tones, first sample without a restart
        restart_pending = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

        // Quarter-cycle steps at full gain: both saturation directions
        load_tones(32'h4000_0000, 32'h0000_7FFF, 32'h4000_0000, 32'h0000_7FFF);
        restart_pending = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

        // Largest step with masked gain, silent second tone with zero step
        load_tones(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        restart_pending = '{1'b1, 1'b0, 1'b0, 1'b1};

        // Random phases: slow receiver, then slow sender, then no idling
        for (int p = 0; p < 3; p++) begin
            drain();
            send_idle_pct <= (p == 0) ? 29 : (p == 1) ? 62 : 0;
            recv_idle_pct <= (p == 0) ? 62 : (p == 1) ? 29 : 0;
            for (int s = 0; s < 4; s++) begin
                load_tones(pick_step(), pick_gain(s == 0), pick_step(), pick_gain(s == 0));
                queue_restarts(42, 8);
                if (s == 2) begin
                    // Pause the sender until the pipeline has emptied
                    while (restart_pending.size() > 20) @(posedge aclk);
                    hold_input <= 1'b1;
                    @(posedge aclk);
                    while (s_tvalid || expected_samples.size() != 0) @(posedge aclk);
                    hold_input <= 1'b0;
                end
            end
        end

        // Let everything drain, with a bound
        for (int w = 0; w < 20000 && (restart_pending.size() != 0 || s_tvalid ||
                                      expected_samples.size() != 0); w++) begin
            @(posedge aclk);
        end
        if (expected_samples.size() != 0) begin
            flag_mismatch("samples never delivered", expected_samples.size(), 0);
        end
        repeat (LATENCY + 4) @(posedge aclk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
